// ===== rtl/wfn_pkg.sv =====
// ----------------------------------------------------------------------------
// wfn_pkg
// Shared types and constants for the sliding-window first-negative block.
// ----------------------------------------------------------------------------
package wfn_pkg;

  localparam int POS_W = 16;
  localparam int CFG_W = 9;
  localparam logic [CFG_W-1:0] CFG_LEN_RESET = 9'd3;

  // Per-beat command broadcast to every queue cell
  typedef struct packed {
    logic clear;
    logic pop;
    logic push;
  } wfn_ctl_t;

endpackage

// ===== rtl/wfn_cell.sv =====
// ----------------------------------------------------------------------------
// wfn_cell
// One slot of the shifting queue: holds a negative sample and its position.
// ----------------------------------------------------------------------------
module wfn_cell #(
  parameter int VALUE_W = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wfn_pkg::wfn_ctl_t       ctl_i,
  input  logic                    prev_valid_i,
  input  logic                    next_valid_i,
  input  logic [VALUE_W-1:0]      next_value_i,
  input  logic [wfn_pkg::POS_W-1:0] next_pos_i,
  input  logic [VALUE_W-1:0]      new_value_i,
  input  logic [wfn_pkg::POS_W-1:0] new_pos_i,
  output logic                    valid_o,
  output logic [VALUE_W-1:0]      value_o,
  output logic [wfn_pkg::POS_W-1:0] pos_o
);
  import wfn_pkg::*;

  logic               valid_q, valid_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic               self_v;
  logic               load_new;

  assign self_v = valid_q & ~ctl_i.clear;

  always_comb begin
    if (ctl_i.pop) begin
      load_new = ctl_i.push & self_v & ~next_valid_i;
      valid_d  = next_valid_i | load_new;
      value_d  = load_new ? new_value_i : next_value_i;
      pos_d    = load_new ? new_pos_i : next_pos_i;
    end else begin
      load_new = ctl_i.push & ~self_v & prev_valid_i;
      valid_d  = self_v | load_new;
      value_d  = load_new ? new_value_i : value_q;
      pos_d    = load_new ? new_pos_i : pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pos_q   <= pos_d;
  end

  assign valid_o = self_v;
  assign value_o = value_q;
  assign pos_o   = pos_q;

endmodule

// ===== rtl/window_first_negative.sv =====
// ----------------------------------------------------------------------------
// window_first_negative
// Oldest negative sample in a sliding window over a signed sample stream.
// ----------------------------------------------------------------------------
// Takes one sample per clock while s_axis_tready is high and returns the result
// of a sample in the cycle after it is accepted; s_axis_tready stays high while
// the output register is empty or being drained. The negative samples of the
// window sit in a row of WINDOW_MAX cells that shift toward the head on a pop,
// so the head update, age check and append all take effect in the same cycle.
// No result is produced until window_length samples (clamped to 1..WINDOW_MAX)
// of the current sequence have been seen; tuser on the input starts a new sequence.
module window_first_negative #(
  parameter int WINDOW_MAX   = 256,
  parameter int SAMPLE_WIDTH = 32,
  localparam int DataW       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [wfn_pkg::CFG_W-1:0] cfg_wdata_i,    // window_length
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [DataW-1:0]          s_axis_tdata,   // sample
  input  logic                      s_axis_tuser,   // new_sequence
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [DataW-1:0]          m_axis_tdata,   // first_negative
  output logic                      m_axis_tuser    // found
);
  import wfn_pkg::*;

  localparam int LenW = $clog2(WINDOW_MAX + 1);
  localparam int CmpW = ((LenW > POS_W) ? LenW : POS_W) + 1;

  logic [CFG_W-1:0]        cfg_len_q;
  logic [LenW-1:0]         len;
  logic [LenW-1:0]         seen_q, seen_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [POS_W-1:0]        cur_pos;
  logic [POS_W-1:0]        age;
  logic                    accept;
  logic                    new_seq;
  logic [SAMPLE_WIDTH-1:0] sample;
  logic                    neg;
  logic                    expired;
  wfn_ctl_t                ctl;
  logic                    emit;
  logic                    head_v_d;
  logic [SAMPLE_WIDTH-1:0] head_val_d;

  logic                    out_valid_q, out_valid_d;
  logic [SAMPLE_WIDTH-1:0] out_data_q, out_data_d;
  logic                    out_found_q, out_found_d;

  logic [WINDOW_MAX-1:0]   cell_v;
  logic [SAMPLE_WIDTH-1:0] cell_val [WINDOW_MAX];
  logic [POS_W-1:0]        cell_pos [WINDOW_MAX];

  assign accept  = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = ~out_valid_q | m_axis_tready;
  assign sample  = s_axis_tdata[SAMPLE_WIDTH-1:0];
  assign new_seq = s_axis_tuser;
  assign neg     = sample[SAMPLE_WIDTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= CFG_LEN_RESET;
    end else if (cfg_we_i) begin
      cfg_len_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (cfg_len_q == '0) begin
      len = LenW'(1);
    end else if (32'(cfg_len_q) > 32'(WINDOW_MAX)) begin
      len = LenW'(WINDOW_MAX);
    end else begin
      len = LenW'(cfg_len_q);
    end
  end

  // Cell valids are already masked by clear
  assign cur_pos   = new_seq ? '0 : pos_q;
  assign age       = cur_pos - cell_pos[0];
  assign expired   = CmpW'(age) >= CmpW'(len);
  assign ctl.clear = accept & new_seq;
  assign ctl.push  = accept & neg;
  assign ctl.pop   = accept & cell_v[0] & (expired | (neg & cell_v[WINDOW_MAX-1]));

  always_comb begin
    if (ctl.pop) begin
      head_v_d   = cell_v[1] | ctl.push;
      head_val_d = cell_v[1] ? cell_val[1] : sample;
    end else begin
      head_v_d   = cell_v[0] | ctl.push;
      head_val_d = cell_v[0] ? cell_val[0] : sample;
    end
  end

  always_comb begin
    pos_d  = pos_q;
    seen_d = seen_q;
    if (accept) begin
      pos_d  = cur_pos + POS_W'(1);
      seen_d = new_seq ? '0 : seen_q;
      if (seen_d < len) begin
        seen_d = seen_d + LenW'(1);
      end
    end
  end

  assign emit = seen_d >= len;

  always_comb begin
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;
    out_found_d = out_found_q;
    if (accept) begin
      out_valid_d = emit;
      out_found_d = head_v_d;
      out_data_d  = head_v_d ? head_val_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    out_found_q <= out_found_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DataW'(out_data_q);
  assign m_axis_tuser  = out_found_q;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic                    prev_v;
    logic                    next_v;
    logic [SAMPLE_WIDTH-1:0] next_val;
    logic [POS_W-1:0]        next_pos;

    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_v = cell_v[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign next_v   = 1'b0;
      assign next_val = '0;
      assign next_pos = '0;
    end else begin : g_link
      assign next_v   = cell_v[i+1];
      assign next_val = cell_val[i+1];
      assign next_pos = cell_pos[i+1];
    end

    wfn_cell #(
      .VALUE_W (SAMPLE_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .prev_valid_i (prev_v),
      .next_valid_i (next_v),
      .next_value_i (next_val),
      .next_pos_i   (next_pos),
      .new_value_i  (sample),
      .new_pos_i    (cur_pos),
      .valid_o      (cell_v[i]),
      .value_o      (cell_val[i]),
      .pos_o        (cell_pos[i])
    );
  end

  // Occupied cells always form a prefix of the row
  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_v >> 1) & ~cell_v) == '0)
    else $error("queue cells not contiguous");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && new_seq) |=> ($countones(cell_v) <= 1))
    else $error("new sequence left stale entries");

  a_grow_by_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !new_seq) |=> ($countones(cell_v) <= $past($countones(cell_v)) + 1))
    else $error("queue grew by more than one");

  a_found_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_found_q) |-> out_data_q[SAMPLE_WIDTH-1])
    else $error("found result is not negative");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_data_q == '0))
    else $error("empty window result is not zero");

endmodule
